// ----- hdl/mtrp_pkg.sv -----
// Shared types and constants for the Modbus TCP response parser.
// No dependencies; used by every module of the block.
package mtrp_pkg;

    localparam int COIL_W     = 11;
    localparam int JOBQ_DEPTH = 4;
    localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);

    localparam logic [7:0] FC_READ_COILS   = 8'd1;
    localparam logic [7:0] FC_READ_HOLDING = 8'd3;

    localparam logic [2:0] HDR_TID_HI = 3'd0;
    localparam logic [2:0] HDR_TID_LO = 3'd1;
    localparam logic [2:0] HDR_LEN_HI = 3'd4;
    localparam logic [2:0] HDR_LEN_LO = 3'd5;

    localparam logic [15:0] BODY_PREFIX = 16'd3;
    localparam logic [3:0]  COILS_PER_BYTE = 4'd8;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_UNIT,
        PH_FUNC,
        PH_COUNT,
        PH_DATA,
        PH_SKIP
    } t_phase;

    typedef struct packed {
        logic [15:0] idx;
        logic [15:0] val;
        logic        coil;
        logic [3:0]  cnt;
    } t_job;

endpackage

// ----- hdl/mtrp_front.sv -----
// Frame parser: accepts stream bytes, tracks header and body, issues store jobs.
// Depends on mtrp_pkg.
module mtrp_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [7:0]                 i_rx_byte,
    input  logic                       i_cfg_we,
    input  logic [mtrp_pkg::COIL_W-1:0] i_cfg_data,
    output logic                       o_job_valid,
    output mtrp_pkg::t_job             o_job
);

    mtrp_pkg::t_phase r_phase, n_phase;
    logic [2:0]  r_hdr_cnt, n_hdr_cnt;
    logic [15:0] r_base, n_base;
    logic [15:0] r_flen, n_flen;
    logic [15:0] r_bpos, n_bpos;
    logic        r_coils, n_coils;
    logic [7:0]  r_dbc, n_dbc;
    logic [7:0]  r_hold, n_hold;
    logic [mtrp_pkg::COIL_W-1:0] r_coil_count;

    logic [15:0] flen_new;
    logic [15:0] bpos_inc;
    logic        frame_end;
    logic [15:0] k;
    logic [14:0] w;
    logic        coil_in_range;
    logic        word_in_range;
    logic [11:0] coil_left;
    logic [3:0]  coil_num;

    always_comb begin
        flen_new = r_flen;
        if (r_hdr_cnt == mtrp_pkg::HDR_LEN_HI) begin
            flen_new = {i_rx_byte, 8'h00};
        end else if (r_hdr_cnt == mtrp_pkg::HDR_LEN_LO) begin
            flen_new = {r_flen[15:8], i_rx_byte};
        end
    end

    assign bpos_inc  = r_bpos + 16'd1;
    assign frame_end = (bpos_inc >= r_flen);
    assign k         = r_bpos - mtrp_pkg::BODY_PREFIX;
    assign w         = k[15:1];

    assign coil_in_range = (k < {8'h00, r_dbc});
    assign word_in_range = (w < {8'h00, r_dbc[7:1]});
    assign coil_left     = {1'b0, r_coil_count} - {1'b0, k[7:0], 3'b000};

    always_comb begin
        if (coil_left[11] || coil_left == 12'd0) begin
            coil_num = 4'd0;
        end else if (coil_left[10:3] != 8'd0) begin
            coil_num = mtrp_pkg::COILS_PER_BYTE;
        end else begin
            coil_num = coil_left[3:0];
        end
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            case (r_phase)
                mtrp_pkg::PH_HEADER: begin
                    if (r_hdr_cnt >= mtrp_pkg::HDR_LEN_LO) begin
                        n_phase = (flen_new == 16'd0) ? mtrp_pkg::PH_HEADER
                                                      : mtrp_pkg::PH_UNIT;
                    end
                end
                mtrp_pkg::PH_UNIT:  n_phase = mtrp_pkg::PH_FUNC;
                mtrp_pkg::PH_FUNC: begin
                    if (i_rx_byte == mtrp_pkg::FC_READ_COILS ||
                        i_rx_byte == mtrp_pkg::FC_READ_HOLDING) begin
                        n_phase = mtrp_pkg::PH_COUNT;
                    end else begin
                        n_phase = mtrp_pkg::PH_SKIP;
                    end
                end
                mtrp_pkg::PH_COUNT: n_phase = mtrp_pkg::PH_DATA;
                mtrp_pkg::PH_DATA:  n_phase = mtrp_pkg::PH_DATA;
                default:            n_phase = mtrp_pkg::PH_SKIP;
            endcase
            if (r_phase != mtrp_pkg::PH_HEADER && frame_end) begin
                n_phase = mtrp_pkg::PH_HEADER;
            end
        end
    end

    // datapath registers
    always_comb begin
        n_hdr_cnt = r_hdr_cnt;
        n_base    = r_base;
        n_flen    = r_flen;
        n_bpos    = r_bpos;
        n_coils   = r_coils;
        n_dbc     = r_dbc;
        n_hold    = r_hold;
        if (i_accept) begin
            if (r_phase == mtrp_pkg::PH_HEADER) begin
                n_flen = flen_new;
                if (r_hdr_cnt == mtrp_pkg::HDR_TID_HI) begin
                    n_base = {i_rx_byte, 8'h00};
                end else if (r_hdr_cnt == mtrp_pkg::HDR_TID_LO) begin
                    n_base = {r_base[15:8], i_rx_byte};
                end
                if (r_hdr_cnt >= mtrp_pkg::HDR_LEN_LO) begin
                    n_hdr_cnt = 3'd0;
                    n_bpos    = 16'd0;
                end else begin
                    n_hdr_cnt = r_hdr_cnt + 3'd1;
                end
            end else begin
                if (r_phase == mtrp_pkg::PH_FUNC) begin
                    n_coils = (i_rx_byte == mtrp_pkg::FC_READ_COILS);
                end
                if (r_phase == mtrp_pkg::PH_COUNT) begin
                    n_dbc = i_rx_byte;
                end
                if (r_phase == mtrp_pkg::PH_DATA && !r_coils && word_in_range && !k[0]) begin
                    n_hold = i_rx_byte;
                end
                if (frame_end) begin
                    n_hdr_cnt = 3'd0;
                    n_bpos    = 16'd0;
                end else begin
                    n_bpos = bpos_inc;
                end
            end
        end
    end

    // outputs
    always_comb begin
        o_job_valid = 1'b0;
        o_job.coil  = r_coils;
        if (r_coils) begin
            o_job.idx = r_base + {5'd0, k[7:0], 3'b000};
            o_job.val = {8'h00, i_rx_byte};
            o_job.cnt = coil_num;
        end else begin
            o_job.idx = r_base + {1'b0, w};
            o_job.val = {r_hold, i_rx_byte};
            o_job.cnt = 4'd1;
        end
        if (i_accept && r_phase == mtrp_pkg::PH_DATA) begin
            if (r_coils) begin
                o_job_valid = coil_in_range && (coil_num != 4'd0);
            end else begin
                o_job_valid = word_in_range && k[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= mtrp_pkg::PH_HEADER;
            r_hdr_cnt    <= 3'd0;
            r_base       <= 16'd0;
            r_flen       <= 16'd0;
            r_bpos       <= 16'd0;
            r_coils      <= 1'b0;
            r_dbc        <= 8'd0;
            r_hold       <= 8'd0;
            r_coil_count <= '0;
        end else begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_base    <= n_base;
            r_flen    <= n_flen;
            r_bpos    <= n_bpos;
            r_coils   <= n_coils;
            r_dbc     <= n_dbc;
            r_hold    <= n_hold;
            if (i_cfg_we) begin
                r_coil_count <= i_cfg_data;
            end
        end
    end

endmodule

// ----- hdl/mtrp_jobq.sv -----
// Short job queue between the frame parser and the write expander.
// Depends on mtrp_pkg.
module mtrp_jobq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mtrp_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output mtrp_pkg::t_job o_job
);

    localparam int AW = mtrp_pkg::JOBQ_AW;

    mtrp_pkg::t_job r_mem [mtrp_pkg::JOBQ_DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_cnt;
    mtrp_pkg::t_job r_head;
    logic           r_head_valid;
    logic           do_push, do_pop;
    logic           head_load, from_mem, bypass, mem_wr;

    assign o_full    = (r_cnt == (AW+1)'(mtrp_pkg::JOBQ_DEPTH));
    assign o_valid   = r_head_valid;
    assign o_job     = r_head;
    assign do_push   = i_push && !o_full;
    assign do_pop    = i_pop && r_head_valid;
    assign head_load = !r_head_valid || do_pop;
    assign from_mem  = head_load && (r_cnt != '0);
    assign bypass    = head_load && (r_cnt == '0) && do_push;
    assign mem_wr    = do_push && !bypass;

    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_mem[r_wp] <= i_job;
        end
        if (from_mem) begin
            r_head <= r_mem[r_rp];
        end else if (bypass) begin
            r_head <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp         <= '0;
            r_rp         <= '0;
            r_cnt        <= '0;
            r_head_valid <= 1'b0;
        end else begin
            if (mem_wr) begin
                r_wp <= r_wp + AW'(1);
            end
            if (from_mem) begin
                r_rp <= r_rp + AW'(1);
            end
            case ({mem_wr, from_mem})
                2'b10:   r_cnt <= r_cnt + (AW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (AW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
            if (head_load) begin
                r_head_valid <= from_mem || bypass;
            end
        end
    end

endmodule

// ----- hdl/mtrp_back.sv -----
// Write expander: turns queued jobs into store writes through an output register,
// one per cycle while that register is empty or being popped. Depends on mtrp_pkg.
module mtrp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  mtrp_pkg::t_job i_job,
    output logic           o_job_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [15:0]    o_store_index,
    output logic [15:0]    o_store_value,
    output logic           o_last_of_run
);

    logic        r_busy;
    logic [15:0] r_idx;
    logic [15:0] r_val;
    logic        r_coil;
    logic [3:0]  r_left;
    logic        r_out_valid;
    logic [15:0] r_out_idx;
    logic [15:0] r_out_val;
    logic        r_out_last;

    logic advance;
    logic cur_last;
    logic load;

    assign advance   = r_busy && (!r_out_valid || i_pop);
    assign cur_last  = (r_left == 4'd1);
    assign load      = i_job_valid && (!r_busy || (advance && cur_last));
    assign o_job_pop = load;

    assign o_empty       = !r_out_valid;
    assign o_store_index = r_out_idx;
    assign o_store_value = r_out_val;
    assign o_last_of_run = r_out_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_idx  <= i_job.idx;
            r_val  <= i_job.val;
            r_coil <= i_job.coil;
            r_left <= i_job.cnt;
        end else if (advance) begin
            r_idx  <= r_idx + 16'd1;
            r_val  <= {1'b0, r_val[15:1]};
            r_left <= r_left - 4'd1;
        end
        if (advance) begin
            r_out_idx  <= r_idx;
            r_out_val  <= r_coil ? {16{r_val[0]}} : r_val;
            r_out_last <= cur_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (advance && cur_last) begin
                r_busy <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- hdl/modbus_tcp_response_parser.sv -----
// Top level of the Modbus TCP response parser: frame parser, job queue and
// write expander. Depends on mtrp_pkg, mtrp_front, mtrp_jobq, mtrp_back.
//
//   channel   direction  handshake                       payload
//   input     in         push / full                     i_rx_byte
//   result    out        empty / pop                     o_store_index, o_store_value,
//                                                        o_last_of_run
//   config    in         i_cfg_valid / o_cfg_ready       i_cfg_data (coil_count)
//
// One byte is taken per cycle while the job queue has room; nothing else stalls it.
// A read-coils data byte yields up to 8 writes, a register word 1, emitted by the
// expander at one per cycle while its output register is empty or being popped.
// A result passes the queue head, expander job and output registers in turn.
// Synchronous active-low reset; configuration is always ready.
module modbus_tcp_response_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [7:0]                  i_rx_byte,
    output logic                        empty,
    input  logic                        pop,
    output logic [15:0]                 o_store_index,
    output logic signed [15:0]          o_store_value,
    output logic                        o_last_of_run,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [mtrp_pkg::COIL_W-1:0] i_cfg_data
);

    logic           accept;
    logic           q_full;
    logic           job_valid;
    mtrp_pkg::t_job job;
    logic           q_valid;
    mtrp_pkg::t_job q_job;
    logic           q_pop;
    logic [15:0]    store_value;

    assign o_cfg_ready   = 1'b1;
    assign full          = q_full;
    assign accept        = push && !q_full;
    assign o_store_value = store_value;

    mtrp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_job_valid (job_valid),
        .o_job       (job)
    );

    mtrp_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_job   (job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    mtrp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (q_valid),
        .i_job         (q_job),
        .o_job_pop     (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_store_index (o_store_index),
        .o_store_value (store_value),
        .o_last_of_run (o_last_of_run)
    );

`ifndef SYNTHESIS
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result pending after reset");

    a_job_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_valid |-> !q_full)
        else $error("job issued into a full queue");

    a_job_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_valid |-> (job.cnt != 4'd0 && job.cnt <= mtrp_pkg::COILS_PER_BYTE))
        else $error("job write count out of range");

    a_no_job_without_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_valid |-> accept)
        else $error("job issued without an accepted byte");
`endif

endmodule
